[rtl/ilir_pkg.sv]
// Shared constants and types for the indexed list insert/remove block.
// Holds request/status codes, default sizes and the per-cell shift control.
// No dependencies.
package ilir_pkg;

    // Default sizing for the top-level parameters.
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Width of the signed word fields on the stream ports.
    localparam int FIELD_W = 32;

    // Request kind codes.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Request place codes.
    localparam logic [1:0] PLACE_POS   = 2'd0;
    localparam logic [1:0] PLACE_FRONT = 2'd1;
    localparam logic [1:0] PLACE_BACK  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;  // open a slot at the position, shift the tail up
        logic rem;  // drop the position, shift the tail down
    } t_cell_ctl;

endpackage

[rtl/indexed_list_insert_remove.sv]
// Top level of the indexed list insert/remove block.
// Decodes requests, drives the chain of ilir_cell entries, and builds results.
// Depends on ilir_pkg and ilir_cell.
//
// Usage:
//   The slave stream carries one request per beat: tuser holds kind and place,
//   tdata holds position and the word to insert. Every request gives exactly
//   one result beat on the master stream: tuser holds the status, tdata holds
//   the removed word, the new count and the new front and back words.
//   The list lives in a row of CAPACITY cells; an insert or remove shifts all
//   entries behind the position by one place as the request is accepted.
//   Result path: an accepted request moves the block to the response state,
//   which loads the output register, waiting while it still holds a stalled
//   result. In the idle state the block reads the word at the position and
//   shifts the cells; in the response state it reads the new back entry
//   through the same one-hot read mux and loads the output register.
//   A request is held off (tready low) while one is in flight. If the receiver
//   stalls, the finished result waits in the output register; a new request
//   may still be taken, and its result waits until the register frees.
//   Reset clears the count to zero, empties the output register and returns
//   to idle. Cell contents are not cleared; only entries below the count are
//   ever read.
module indexed_list_insert_remove #(
    parameter int CAPACITY   = ilir_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = ilir_pkg::DEF_DATA_WIDTH,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int IN_W      = ((CNT_W + ilir_pkg::FIELD_W + 7) / 8) * 8,
    localparam int OUT_W     = ((3 * ilir_pkg::FIELD_W + CNT_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // position, value, zero fill
    input  logic [2:0]       s_axis_tuser,   // kind, place
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // removed_value, count,
                                             // front_value, back_value, zero fill
    output logic [1:0]       m_axis_tuser    // status
);
    import ilir_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Request fields.
    logic                  w_kind;
    logic [1:0]            w_place;
    logic [CNT_W-1:0]      w_position;
    logic [FIELD_W-1:0]    w_value;
    logic [DATA_WIDTH-1:0] w_din;

    assign w_kind     = s_axis_tuser[0];
    assign w_place    = s_axis_tuser[2:1];
    assign w_position = s_axis_tdata[CNT_W-1:0];
    assign w_value    = s_axis_tdata[CNT_W +: FIELD_W];
    assign w_din      = DATA_WIDTH'($signed(w_value));

    logic                  r_state;
    logic [CNT_W-1:0]      r_count;
    logic [1:0]            r_status;
    logic [DATA_WIDTH-1:0] r_removed;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;
    logic [1:0]            r_out_user;

    logic                  w_accept;
    logic [1:0]            w_status;
    logic [CNT_W-1:0]      w_pos;
    t_cell_ctl             w_ctl;
    logic [CNT_W-1:0]      w_rd_sel;
    logic [DATA_WIDTH-1:0] w_rd;
    logic                  w_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Resolve the list position and the status of the request.
    always_comb begin
        w_pos    = '0;
        w_status = ST_OK;
        case (w_place)
            PLACE_POS: begin
                w_pos = w_position;
                if (w_kind == KIND_INSERT) begin
                    if (w_position > r_count) begin
                        w_status = ST_BAD_INDEX;
                    end else if (r_count == CAP_CNT) begin
                        w_status = ST_FULL;
                    end
                end else if (w_position >= r_count) begin
                    w_status = ST_BAD_INDEX;
                end
            end
            PLACE_FRONT: begin
                w_pos = '0;
                if (w_kind == KIND_INSERT) begin
                    if (r_count == CAP_CNT) begin
                        w_status = ST_FULL;
                    end
                end else if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end
            end
            PLACE_BACK: begin
                if (w_kind == KIND_INSERT) begin
                    w_pos = r_count;
                    if (r_count == CAP_CNT) begin
                        w_status = ST_FULL;
                    end
                end else begin
                    w_pos = r_count - 1'b1;
                    if (r_count == '0) begin
                        w_status = ST_EMPTY;
                    end
                end
            end
            default: begin
                w_status = ST_BAD_INDEX;
            end
        endcase
    end

    assign w_ctl.ins = w_accept && (w_status == ST_OK) && (w_kind == KIND_INSERT);
    assign w_ctl.rem = w_accept && (w_status == ST_OK) && (w_kind == KIND_REMOVE);

    // The read port serves the removed word first, then the new back entry.
    assign w_rd_sel = (r_state == S_IDLE) ? w_pos : (r_count - 1'b1);

    // Chain of cells.
    logic [DATA_WIDTH-1:0] w_q  [CAPACITY];
    logic [DATA_WIDTH-1:0] w_rdp[CAPACITY];

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (gi == 0) begin : g_first
            assign w_left = w_din;
        end else begin : g_mid_l
            assign w_left = w_q[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_q[gi+1];
        end
        ilir_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX        (gi)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_pos    (w_pos),
            .i_din    (w_din),
            .i_left   (w_left),
            .i_right  (w_right),
            .i_rd_sel (w_rd_sel),
            .o_q      (w_q[gi]),
            .o_rd     (w_rdp[gi])
        );
    end

    // One-hot read mux over the cells.
    always_comb begin
        w_rd = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd = w_rd | w_rdp[i];
        end
    end

    // Result fields, sign-extended to the port width.
    logic [FIELD_W-1:0] w_removed_f;
    logic [FIELD_W-1:0] w_front_f;
    logic [FIELD_W-1:0] w_back_f;

    assign w_removed_f = FIELD_W'($signed(r_removed));
    assign w_front_f   = (r_count != '0) ? FIELD_W'($signed(w_q[0])) : '0;
    assign w_back_f    = (r_count != '0) ? FIELD_W'($signed(w_rd)) : '0;

    assign w_load = (r_state == S_RESP) && (!r_out_valid || m_axis_tready);

    // Control state: sequencing, count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_ctl.ins) begin
                r_count <= r_count + 1'b1;
            end else if (w_ctl.rem) begin
                r_count <= r_count - 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers for the request in flight and the output beat.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= w_status;
            r_removed <= w_ctl.rem ? w_rd : '0;
        end
        if (w_load) begin
            r_out_user <= r_status;
            r_out_data <= OUT_W'({w_back_f, w_front_f, r_count, w_removed_f});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

[rtl/ilir_cell.sv]
// One storage cell of the list chain: holds a single entry.
// Takes the new word, or its left or right neighbor's word, when the list shifts.
// Depends on ilir_pkg.
module ilir_cell #(
    parameter int DATA_WIDTH = ilir_pkg::DEF_DATA_WIDTH,
    parameter int CNT_W      = 7,
    parameter int IDX        = 0
) (
    input  logic                   i_clk,
    input  ilir_pkg::t_cell_ctl    i_ctl,
    input  logic [CNT_W-1:0]       i_pos,
    input  logic [DATA_WIDTH-1:0]  i_din,
    input  logic [DATA_WIDTH-1:0]  i_left,
    input  logic [DATA_WIDTH-1:0]  i_right,
    input  logic [CNT_W-1:0]       i_rd_sel,
    output logic [DATA_WIDTH-1:0]  o_q,
    output logic [DATA_WIDTH-1:0]  o_rd
);
    import ilir_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] n_q;

    // Pick the next word from the shift command and this cell's place.
    always_comb begin
        n_q = r_q;
        if (i_ctl.ins) begin
            if (MY_IDX == i_pos) begin
                n_q = i_din;
            end else if (MY_IDX > i_pos) begin
                n_q = i_left;
            end
        end else if (i_ctl.rem) begin
            if (MY_IDX >= i_pos) begin
                n_q = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // This cell's share of the one-hot read mux.
    assign o_rd = (MY_IDX == i_rd_sel) ? r_q : '0;
    assign o_q  = r_q;

endmodule

[rtl/ilir_checker.sv]
// Port-level checker for indexed_list_insert_remove, with its bind.
// Watches the result stream for consistency of status, count and values.
// Depends on ilir_pkg.
module ilir_checker #(
    parameter int CAPACITY = ilir_pkg::DEF_CAPACITY,
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int OUT_W   = ((3 * ilir_pkg::FIELD_W + CNT_W + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [1:0]       m_axis_tuser
);
    import ilir_pkg::*;

    logic [FIELD_W-1:0] w_removed;
    logic [CNT_W-1:0]   w_count;
    logic [FIELD_W-1:0] w_front;
    logic [FIELD_W-1:0] w_back;

    assign w_removed = m_axis_tdata[FIELD_W-1:0];
    assign w_count   = m_axis_tdata[FIELD_W +: CNT_W];
    assign w_front   = m_axis_tdata[FIELD_W + CNT_W +: FIELD_W];
    assign w_back    = m_axis_tdata[2 * FIELD_W + CNT_W +: FIELD_W];

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
        else $error("result beat changed while stalled");

    // A full status only comes with a list at capacity.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> (w_count == CNT_W'(CAPACITY)))
        else $error("full status with list below capacity");

    // An empty list reports zero front and back words.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_count == '0) |-> (w_front == '0) && (w_back == '0))
        else $error("empty list with nonzero front or back");

    // A failed request removes nothing.
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (w_removed == '0))
        else $error("failed request returned a removed word");

    // Reset leaves no result beat pending.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind indexed_list_insert_remove ilir_checker #(
    .CAPACITY (CAPACITY)
) u_ilir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[test/indexed_list_insert_remove_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for indexed_list_insert_remove: directed and random requests
// are checked against a queue-based model of the list. Depends on ilir_pkg and the RTL.
module indexed_list_insert_remove_tb;
    import ilir_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int IN_W         = ((CNT_W + FIELD_W + 7) / 8) * 8;
    localparam int OUT_W        = ((3 * FIELD_W + CNT_W + 7) / 8) * 8;
    localparam logic [1:0] PLACE_NONE = 2'd3;    // place code with no meaning
    localparam int RANDOM_ITEMS = 1425;
    localparam int IDLE_LIMIT   = 1000;          // cycles without any handshake
    localparam int LONG_HOLD    = 300;           // receiver back-pressure stretch
    localparam int HOLD_AT      = 400;           // results seen before that stretch
    localparam int TAIL_CYCLES  = 10;            // settle time after the last result

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} t_mix_mode;

    typedef struct {
        logic               kind;
        logic [1:0]         place;
        logic [CNT_W-1:0]   position;
        logic [FIELD_W-1:0] value;
    } t_list_req;

    typedef struct {
        logic [FIELD_W-1:0] removed;
        logic [1:0]         status;
        logic [CNT_W-1:0]   count;
        logic [FIELD_W-1:0] front;
        logic [FIELD_W-1:0] back;
    } t_list_resp;

    typedef struct {
        t_list_req  req;
        bit         typed;
        t_list_resp resp;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;    // position, value, zero fill
    logic [2:0]       s_axis_tuser = '0;    // kind, place
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // removed_value, count, front_value,
                                            // back_value, zero fill
    logic [1:0]       m_axis_tuser;         // status

    // Model state: the list contents and the results still owed by the block.
    logic [FIELD_W-1:0] list_mirror[$];
    t_list_resp         pending_results[$];
    int                 mismatch_count = 0;
    int                 results_seen = 0;
    int                 idle_cycles = 0;

    indexed_list_insert_remove #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DEF_DATA_WIDTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the list model and return the result it should give.
    function automatic t_list_resp apply_list_request(t_list_req r);
        t_list_resp  o;
        int unsigned n;
        int unsigned pos;
        n = list_mirror.size();
        o = '{default: '0};
        o.status = ST_OK;
        pos = 0;
        if (r.place == PLACE_NONE) begin
            o.status = ST_BAD_INDEX;
        end else if (r.kind == KIND_INSERT) begin
            if (r.place == PLACE_POS) pos = r.position;
            else if (r.place == PLACE_FRONT) pos = 0;
            else pos = n;
            if (pos > n) o.status = ST_BAD_INDEX;
            else if (n >= CAPACITY) o.status = ST_FULL;
            else list_mirror.insert(pos, r.value);
        end else begin
            if (r.place == PLACE_POS) begin
                if (r.position >= n) o.status = ST_BAD_INDEX;
                else pos = r.position;
            end else if (n == 0) begin
                o.status = ST_EMPTY;
            end else begin
                pos = (r.place == PLACE_FRONT) ? 0 : n - 1;
            end
            if (o.status == ST_OK) begin
                o.removed = list_mirror[pos];
                list_mirror.delete(pos);
            end
        end
        o.count = CNT_W'(list_mirror.size());
        if (list_mirror.size() > 0) begin
            o.front = list_mirror[0];
            o.back  = list_mirror[list_mirror.size() - 1];
        end
        return o;
    endfunction

    // One row of the directed table; typed rows carry their result by hand.
    function automatic t_dir_row make_row(logic kind, logic [1:0] place, int pos,
                                          logic [FIELD_W-1:0] value, bit typed,
                                          logic [1:0] status, int count,
                                          logic [FIELD_W-1:0] front,
                                          logic [FIELD_W-1:0] back);
        t_dir_row d;
        d.req   = '{kind, place, CNT_W'(pos), value};
        d.typed = typed;
        d.resp  = '{'0, status, CNT_W'(count), front, back};
        return d;
    endfunction

    // Insert word: extremes now and then, otherwise any 32-bit pattern.
    function automatic logic [FIELD_W-1:0] draw_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Random request, biased by mode toward filling, draining or a balance.
    function automatic t_list_req draw_request(t_mix_mode mode);
        t_list_req   r;
        int unsigned n;
        int unsigned pick;
        n = list_mirror.size();
        case (mode)
            MODE_FILL:  r.kind = ($urandom_range(0, 99) < 85) ? KIND_INSERT : KIND_REMOVE;
            MODE_DRAIN: r.kind = ($urandom_range(0, 99) < 85) ? KIND_REMOVE : KIND_INSERT;
            default:    r.kind = 1'($urandom_range(0, 1));
        endcase
        pick = $urandom_range(0, 19);
        if (pick == 0) r.place = PLACE_NONE;
        else if (pick <= 6) r.place = PLACE_FRONT;
        else if (pick <= 12) r.place = PLACE_BACK;
        else r.place = PLACE_POS;
        // Mostly valid positions; the rest land beyond the list, up to the field limit.
        if ($urandom_range(0, 99) < 85) begin
            if (r.kind == KIND_INSERT) r.position = CNT_W'($urandom_range(0, n));
            else r.position = (n > 0) ? CNT_W'($urandom_range(0, n - 1)) : '0;
        end else begin
            if (r.kind == KIND_INSERT) r.position = CNT_W'($urandom_range(n + 1, 127));
            else r.position = CNT_W'($urandom_range(n, 127));
        end
        r.value = draw_word();
        return r;
    endfunction

    // Offer one request after a gap, wait for it to be taken, then record the result owed.
    task automatic send_request(t_list_req r, bit typed, t_list_resp typed_resp, int gap);
        t_list_resp predicted;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({r.value, r.position});
        s_axis_tuser  <= {r.place, r.kind};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = apply_list_request(r);
        pending_results.push_back(typed ? typed_resp : predicted);
    endtask

    // Compare a result taken from the master side with the oldest one owed.
    task automatic check_result();
        t_list_resp act;
        t_list_resp exp_r;
        act.removed = m_axis_tdata[0 +: FIELD_W];
        act.count   = m_axis_tdata[FIELD_W +: CNT_W];
        act.front   = m_axis_tdata[FIELD_W + CNT_W +: FIELD_W];
        act.back    = m_axis_tdata[2 * FIELD_W + CNT_W +: FIELD_W];
        act.status  = m_axis_tuser;
        results_seen++;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d arrived with none outstanding: status=%0d count=%0d",
                         results_seen, act.status, act.count);
        end else begin
            exp_r = pending_results.pop_front();
            if (act.removed !== exp_r.removed || act.status !== exp_r.status ||
                act.count !== exp_r.count || act.front !== exp_r.front ||
                act.back !== exp_r.back) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display({"result %0d expected removed=%0d status=%0d count=%0d",
                              " front=%0d back=%0d"},
                             results_seen, $signed(exp_r.removed), exp_r.status, exp_r.count,
                             $signed(exp_r.front), $signed(exp_r.back));
                    $display({"result %0d actual   removed=%0d status=%0d count=%0d",
                              " front=%0d back=%0d"},
                             results_seen, $signed(act.removed), act.status, act.count,
                             $signed(act.front), $signed(act.back));
                end
            end
        end
    endtask

    // Receiver: random stalls per result, quiet stretches, and one long hold-off.
    initial begin
        int stall;
        int stretch_left;
        bit recv_idle;
        stretch_left = 0;
        recv_idle = 1'b0;
        wait (i_rst_n);
        forever begin
            if (stretch_left == 0) begin
                recv_idle    = ($urandom_range(0, 3) != 0);
                stretch_left = $urandom_range(20, 100);
            end
            stretch_left--;
            if (results_seen == HOLD_AT) stall = LONG_HOLD;
            else stall = recv_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            check_result();
        end
    end

    // Watchdog: ends the run when no request or result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[indexed_list_insert_remove] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sender: reset, directed table, then phased random traffic.
    initial begin
        t_dir_row   rows[$];
        t_list_resp none;
        t_list_req  r;
        t_mix_mode  mode;
        int         phase_left;
        int         phase_no;
        bit         send_idle;
        none = '{default: '0};
        mode = MODE_FILL;
        phase_left = 0;
        phase_no = 0;
        send_idle = 1'b0;

        // Empty-list errors, extremes, every place, and positions at and past the end.
        rows.push_back(make_row(KIND_REMOVE, PLACE_FRONT, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_BACK, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_POS, 0, 0, 1, ST_BAD_INDEX, 0, 0, 0));
        rows.push_back(make_row(KIND_INSERT, PLACE_POS, 1, 7, 1, ST_BAD_INDEX, 0, 0, 0));
        rows.push_back(make_row(KIND_INSERT, PLACE_NONE, 0, 9, 1, ST_BAD_INDEX, 0, 0, 0));
        rows.push_back(make_row(KIND_INSERT, PLACE_BACK, 0, 32'h7FFF_FFFF, 1, ST_OK, 1,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF));
        rows.push_back(make_row(KIND_INSERT, PLACE_FRONT, 0, 32'h8000_0000, 1, ST_OK, 2,
                                32'h8000_0000, 32'h7FFF_FFFF));
        rows.push_back(make_row(KIND_INSERT, PLACE_POS, 1, 0, 1, ST_OK, 3,
                                32'h8000_0000, 32'h7FFF_FFFF));
        rows.push_back(make_row(KIND_INSERT, PLACE_POS, 3, 32'hFFFF_FFFF, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_INSERT, PLACE_POS, 127, 5, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_POS, 1, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_NONE, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_BACK, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_FRONT, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_INSERT, PLACE_POS, 0, 32'h5555_5555, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_INSERT, PLACE_POS, 2, 32'hAAAA_AAAA, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_POS, 2, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_POS, 2, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_POS, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_BACK, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_BACK, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        rows.push_back(make_row(KIND_INSERT, PLACE_POS, 0, 123, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_INSERT, PLACE_NONE, 0, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_POS, 127, 0, 0, ST_OK, 0, 0, 0));
        rows.push_back(make_row(KIND_REMOVE, PLACE_FRONT, 0, 0, 0, ST_OK, 0, 0, 0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i])
            send_request(rows[i].req, rows[i].typed, rows[i].resp, $urandom_range(0, 14));

        // The first two phases fill the list past full and drain it past empty.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                if (phase_no == 0) mode = MODE_FILL;
                else if (phase_no == 1) mode = MODE_DRAIN;
                else mode = t_mix_mode'($urandom_range(0, 2));
                phase_left = (phase_no < 2) ? 150 : $urandom_range(30, 120);
                send_idle  = ($urandom_range(0, 3) != 0);
                phase_no++;
            end
            phase_left--;
            // Halfway through, let every outstanding result come back first.
            if (n == RANDOM_ITEMS / 2 && pending_results.size() != 0) begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            r = draw_request(mode);
            send_request(r, 1'b0, none, send_idle ? $urandom_range(0, 14) : 0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[indexed_list_insert_remove] OK");
        end else begin
            $display("[indexed_list_insert_remove] ERROR");
        end
        $finish;
    end

endmodule
